// ===== rtl/mise_pkg.sv =====
// shared types and constants for the mips integer subset executor
// opcode, funct, status and configuration index codes; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package mise_pkg;

    localparam int unsigned XLEN     = 32;
    localparam int unsigned REG_AW   = 5;
    localparam int unsigned REG_N    = 32;
    localparam int unsigned CFG_AW   = 2;

    // configuration register indexes
    localparam logic [CFG_AW-1:0] CFG_START_PC   = 2'd0;
    localparam logic [CFG_AW-1:0] CFG_BREAK_ADDR = 2'd1;
    localparam logic [CFG_AW-1:0] CFG_BREAK_EN   = 2'd2;

    // status codes
    localparam logic [1:0] ST_RUN    = 2'd0;
    localparam logic [1:0] ST_BREAK  = 2'd1;
    localparam logic [1:0] ST_UNALGN = 2'd2;
    localparam logic [1:0] ST_FUNCT  = 2'd3;

    // input action codes
    localparam logic ACT_INSN = 1'b0;
    localparam logic ACT_LOAD = 1'b1;

    // primary opcodes
    localparam logic [5:0] OP_SPECIAL = 6'h00;
    localparam logic [5:0] OP_BNE     = 6'h05;
    localparam logic [5:0] OP_ADDI    = 6'h08;
    localparam logic [5:0] OP_ADDIU   = 6'h09;
    localparam logic [5:0] OP_SLTI    = 6'h0A;
    localparam logic [5:0] OP_SLTIU   = 6'h0B;
    localparam logic [5:0] OP_ANDI    = 6'h0C;
    localparam logic [5:0] OP_ORI     = 6'h0D;
    localparam logic [5:0] OP_XORI    = 6'h0E;
    localparam logic [5:0] OP_LUI     = 6'h0F;
    localparam logic [5:0] OP_LW      = 6'h23;
    localparam logic [5:0] OP_SW      = 6'h2B;

    // special funct codes
    localparam logic [5:0] FN_SLL  = 6'h00;
    localparam logic [5:0] FN_SRL  = 6'h02;
    localparam logic [5:0] FN_SRA  = 6'h03;
    localparam logic [5:0] FN_JR   = 6'h08;
    localparam logic [5:0] FN_JALR = 6'h09;
    localparam logic [5:0] FN_ADD  = 6'h20;
    localparam logic [5:0] FN_ADDU = 6'h21;
    localparam logic [5:0] FN_SUB  = 6'h22;
    localparam logic [5:0] FN_SUBU = 6'h23;
    localparam logic [5:0] FN_AND  = 6'h24;
    localparam logic [5:0] FN_OR   = 6'h25;
    localparam logic [5:0] FN_XOR  = 6'h26;
    localparam logic [5:0] FN_NOR  = 6'h27;
    localparam logic [5:0] FN_SLT  = 6'h2A;
    localparam logic [5:0] FN_SLTU = 6'h2B;

    typedef struct packed {
        logic              en;
        logic [REG_AW-1:0] addr;
        logic [XLEN-1:0]   data;
    } t_rf_wr;

endpackage

`default_nettype wire

// ===== rtl/mise_regfile.sv =====
// 32 x 32 register file with registered two-port read and write-first forwarding
// depends on mise_pkg for widths and the write port struct
`timescale 1ns / 1ps
`default_nettype none

module mise_regfile (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_rd_en,
    input  wire logic [mise_pkg::REG_AW-1:0]  i_rs_addr,
    input  wire logic [mise_pkg::REG_AW-1:0]  i_rt_addr,
    input  wire mise_pkg::t_rf_wr             i_wr,
    output logic      [mise_pkg::XLEN-1:0]    o_rs_data,
    output logic      [mise_pkg::XLEN-1:0]    o_rt_data
);

    logic [mise_pkg::XLEN-1:0]  r_mem [mise_pkg::REG_N];
    logic [mise_pkg::REG_N-1:0] r_vld;
    logic [mise_pkg::XLEN-1:0]  r_rs_data;
    logic [mise_pkg::XLEN-1:0]  r_rt_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    // entries read as zero until first written
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_wr.en) begin
            r_vld[i_wr.addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            if (i_wr.en && (i_wr.addr == i_rs_addr)) begin
                r_rs_data <= i_wr.data;
            end else if (r_vld[i_rs_addr]) begin
                r_rs_data <= r_mem[i_rs_addr];
            end else begin
                r_rs_data <= '0;
            end
            if (i_wr.en && (i_wr.addr == i_rt_addr)) begin
                r_rt_data <= i_wr.data;
            end else if (r_vld[i_rt_addr]) begin
                r_rt_data <= r_mem[i_rt_addr];
            end else begin
                r_rt_data <= '0;
            end
        end
    end

    assign o_rs_data = r_rs_data;
    assign o_rt_data = r_rt_data;

    a_no_r0_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_wr.en |-> (i_wr.addr != '0))
        else $error("register zero written");

endmodule

`default_nettype wire

// ===== rtl/mips_integer_subset_executor.sv =====
// top level of the mips integer subset executor
// depends on mise_pkg and mise_regfile
`timescale 1ns / 1ps
`default_nettype none

// Each transaction on the input channel is either an instruction word for the
// current fetch address or the data word of the pending load; each produces one
// result transaction with the next fetch address, the memory request, status and
// retired count. An accepted transaction is held in an input register while
// the register file is read, then executes and lands in the output register;
// one transaction is taken every cycle as long as the output side keeps up;
// the output register holding a result stalls the pipe only when it is not
// taken. The register file reads zero after reset without any clearing pass.
// Configuration writes are taken in every cycle and should be issued only while
// the block is idle; writing start_pc also moves the fetch address.
module mips_integer_subset_executor (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [mise_pkg::CFG_AW-1:0]    i_cfg_index,
    input  wire logic [mise_pkg::XLEN-1:0]      i_cfg_data,
    input  wire logic                           i_in_valid,
    output logic                                o_in_ready,
    input  wire logic                           i_action,
    input  wire logic [31:0]                    i_word,
    output logic                                o_out_valid,
    input  wire logic                           i_out_ready,
    output logic      [31:0]                    o_fetch_address,
    output logic                                o_mem_read,
    output logic                                o_mem_write,
    output logic      [31:0]                    o_mem_address,
    output logic      [31:0]                    o_mem_wdata,
    output logic      [1:0]                     o_status,
    output logic      [31:0]                    o_retired_count
);

    // configuration
    logic [31:0] r_break_addr;
    logic        r_break_en;

    // input stage
    logic        r_in_valid;
    logic        r_act;
    logic [31:0] r_word;
    logic [31:0] rs_data;
    logic [31:0] rt_data;

    // architectural state
    logic [31:0] r_pc,       n_pc;
    logic        r_br_pend,  n_br_pend;
    logic [31:0] r_br_tgt,   n_br_tgt;
    logic        r_ld_pend,  n_ld_pend;
    logic [4:0]  r_ld_dest,  n_ld_dest;
    logic [31:0] r_ld_addr,  n_ld_addr;
    logic [1:0]  r_halt,     n_halt;
    logic [31:0] r_count,    n_count;

    // output stage
    logic        r_out_valid;
    logic [31:0] r_o_fetch;
    logic        r_o_mrd;
    logic        r_o_mwr;
    logic [31:0] r_o_maddr;
    logic [31:0] r_o_wdata;
    logic [1:0]  r_o_status;
    logic [31:0] r_o_count;

    logic            in_fire;
    logic            ex_fire;
    logic            cfg_fire;
    mise_pkg::t_rf_wr rf_wr;

    // execute signals
    logic        ex_store;
    logic [31:0] ex_saddr;
    logic [31:0] ex_sdata;
    logic [5:0]  op;
    logic [5:0]  fn;
    logic [4:0]  rt;
    logic [4:0]  rd;
    logic [4:0]  sh;
    logic [31:0] imm;
    logic [31:0] simm;
    logic [1:0]  pre_halt;
    logic        wr_en;
    logic [4:0]  wr_addr;
    logic [31:0] wr_data;
    logic        known;
    logic        set_br;
    logic [31:0] set_tgt;

    assign cfg_fire    = i_cfg_valid;
    assign o_cfg_ready = 1'b1;
    assign ex_fire     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || ex_fire;
    assign in_fire     = i_in_valid && o_in_ready;

    mise_regfile u_regfile (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (in_fire),
        .i_rs_addr (i_word[25:21]),
        .i_rt_addr (i_word[20:16]),
        .i_wr      (rf_wr),
        .o_rs_data (rs_data),
        .o_rt_data (rt_data)
    );

    always_comb begin
        op       = r_word[31:26];
        fn       = r_word[5:0];
        rt       = r_word[20:16];
        rd       = r_word[15:11];
        sh       = r_word[10:6];
        imm      = {16'h0000, r_word[15:0]};
        simm     = {{16{r_word[15]}}, r_word[15:0]};
        n_pc      = r_pc;
        n_br_pend = r_br_pend;
        n_br_tgt  = r_br_tgt;
        n_ld_pend = r_ld_pend;
        n_ld_dest = r_ld_dest;
        n_ld_addr = r_ld_addr;
        n_halt    = r_halt;
        n_count   = r_count;
        ex_store  = 1'b0;
        ex_saddr  = '0;
        ex_sdata  = '0;
        wr_en     = 1'b0;
        wr_addr   = rd;
        wr_data   = '0;
        known     = 1'b1;
        set_br    = 1'b0;
        set_tgt   = rs_data;
        pre_halt  = r_halt;

        if (r_act == mise_pkg::ACT_LOAD) begin
            if (r_ld_pend) begin
                wr_en     = 1'b1;
                wr_addr   = r_ld_dest;
                wr_data   = r_word;
                n_ld_pend = 1'b0;
            end
        end else if (!r_ld_pend) begin
            if (r_halt == mise_pkg::ST_RUN) begin
                if (r_break_en && (r_pc == r_break_addr)) begin
                    pre_halt = mise_pkg::ST_BREAK;
                end else if (r_pc[1:0] != 2'b00) begin
                    pre_halt = mise_pkg::ST_UNALGN;
                end
            end
            n_halt = pre_halt;
            if (pre_halt == mise_pkg::ST_RUN) begin
                if (op == mise_pkg::OP_SPECIAL) begin
                    wr_addr = rd;
                    case (fn)
                        mise_pkg::FN_ADD, mise_pkg::FN_ADDU: begin
                            wr_en = 1'b1; wr_data = rs_data + rt_data;
                        end
                        mise_pkg::FN_SUB, mise_pkg::FN_SUBU: begin
                            wr_en = 1'b1; wr_data = rs_data - rt_data;
                        end
                        mise_pkg::FN_AND: begin
                            wr_en = 1'b1; wr_data = rs_data & rt_data;
                        end
                        mise_pkg::FN_OR: begin
                            wr_en = 1'b1; wr_data = rs_data | rt_data;
                        end
                        mise_pkg::FN_XOR: begin
                            wr_en = 1'b1; wr_data = rs_data ^ rt_data;
                        end
                        mise_pkg::FN_NOR: begin
                            wr_en = 1'b1; wr_data = ~(rs_data | rt_data);
                        end
                        mise_pkg::FN_SLL: begin
                            wr_en = 1'b1; wr_data = rt_data << sh;
                        end
                        mise_pkg::FN_SRL: begin
                            wr_en = 1'b1; wr_data = rt_data >> sh;
                        end
                        mise_pkg::FN_SRA: begin
                            wr_en = 1'b1; wr_data = $unsigned($signed(rt_data) >>> sh);
                        end
                        mise_pkg::FN_SLT: begin
                            wr_en   = 1'b1;
                            wr_data = {31'd0, $signed(rs_data) < $signed(rt_data)};
                        end
                        mise_pkg::FN_SLTU: begin
                            wr_en = 1'b1; wr_data = {31'd0, rs_data < rt_data};
                        end
                        mise_pkg::FN_JR: begin
                            set_br = 1'b1; set_tgt = rs_data;
                        end
                        mise_pkg::FN_JALR: begin
                            set_br  = 1'b1; set_tgt = rs_data;
                            wr_en   = 1'b1; wr_data = r_pc + 32'd8;
                        end
                        default: begin
                            known = 1'b0;
                        end
                    endcase
                end else begin
                    wr_addr = rt;
                    case (op)
                        mise_pkg::OP_SW: begin
                            ex_store = 1'b1;
                            ex_saddr = rs_data + simm;
                            ex_sdata = rt_data;
                        end
                        mise_pkg::OP_LW: begin
                            n_ld_pend = 1'b1;
                            n_ld_dest = rt;
                            n_ld_addr = rs_data + simm;
                        end
                        mise_pkg::OP_ADDI, mise_pkg::OP_ADDIU: begin
                            wr_en = 1'b1; wr_data = rs_data + simm;
                        end
                        mise_pkg::OP_SLTI: begin
                            wr_en   = 1'b1;
                            wr_data = {31'd0, $signed(rs_data) < $signed(simm)};
                        end
                        mise_pkg::OP_SLTIU: begin
                            wr_en = 1'b1; wr_data = {31'd0, rs_data < simm};
                        end
                        mise_pkg::OP_ANDI: begin
                            wr_en = 1'b1; wr_data = rs_data & imm;
                        end
                        mise_pkg::OP_ORI: begin
                            wr_en = 1'b1; wr_data = rs_data | imm;
                        end
                        mise_pkg::OP_XORI: begin
                            wr_en = 1'b1; wr_data = rs_data ^ imm;
                        end
                        mise_pkg::OP_LUI: begin
                            wr_en = 1'b1; wr_data = {r_word[15:0], 16'h0000};
                        end
                        mise_pkg::OP_BNE: begin
                            set_br  = (rs_data != rt_data);
                            set_tgt = r_pc + 32'd4 + {simm[29:0], 2'b00};
                        end
                        default: begin
                        end
                    endcase
                end

                n_count = r_count + 32'd1;
                if (!known) begin
                    n_halt = mise_pkg::ST_FUNCT;
                end else begin
                    n_br_pend = set_br;
                    if (set_br) begin
                        n_br_tgt = set_tgt;
                    end
                    n_pc = r_br_pend ? r_br_tgt : (r_pc + 32'd4);
                    if (r_break_en && (n_pc == r_break_addr)) begin
                        n_halt = mise_pkg::ST_BREAK;
                    end else if (n_pc[1:0] != 2'b00) begin
                        n_halt = mise_pkg::ST_UNALGN;
                    end
                end
            end
        end
    end

    always_comb begin
        rf_wr.en   = ex_fire && wr_en && (wr_addr != '0);
        rf_wr.addr = wr_addr;
        rf_wr.data = wr_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_act  <= i_action;
            r_word <= i_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_break_addr <= '0;
            r_break_en   <= 1'b0;
            r_pc         <= '0;
            r_br_pend    <= 1'b0;
            r_br_tgt     <= '0;
            r_ld_pend    <= 1'b0;
            r_ld_dest    <= '0;
            r_ld_addr    <= '0;
            r_halt       <= mise_pkg::ST_RUN;
            r_count      <= '0;
        end else begin
            if (ex_fire) begin
                r_pc      <= n_pc;
                r_br_pend <= n_br_pend;
                r_br_tgt  <= n_br_tgt;
                r_ld_pend <= n_ld_pend;
                r_ld_dest <= n_ld_dest;
                r_ld_addr <= n_ld_addr;
                r_halt    <= n_halt;
                r_count   <= n_count;
            end
            if (cfg_fire) begin
                case (i_cfg_index)
                    mise_pkg::CFG_START_PC: begin
                        r_pc <= i_cfg_data;
                    end
                    mise_pkg::CFG_BREAK_ADDR: begin
                        r_break_addr <= i_cfg_data;
                    end
                    mise_pkg::CFG_BREAK_EN: begin
                        r_break_en <= i_cfg_data[0];
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ex_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ex_fire) begin
            r_o_fetch  <= n_pc;
            r_o_mrd    <= n_ld_pend;
            r_o_mwr    <= ex_store;
            r_o_maddr  <= ex_store ? ex_saddr : (n_ld_pend ? n_ld_addr : 32'd0);
            r_o_wdata  <= ex_sdata;
            r_o_status <= n_halt;
            r_o_count  <= n_count;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_fetch_address = r_o_fetch;
    assign o_mem_read      = r_o_mrd;
    assign o_mem_write     = r_o_mwr;
    assign o_mem_address   = r_o_maddr;
    assign o_mem_wdata     = r_o_wdata;
    assign o_status        = r_o_status;
    assign o_retired_count = r_o_count;

    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_halt != mise_pkg::ST_RUN) |=> (r_halt == $past(r_halt)))
        else $error("halt status changed before reset");

    a_rd_wr_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_mem_read && o_mem_write))
        else $error("load and store requested together");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ex_fire |=> ((r_count == $past(r_count)) || (r_count == $past(r_count) + 32'd1)))
        else $error("retired count jumped");

    a_halt_no_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ex_fire && (r_halt != mise_pkg::ST_RUN)) |=> $stable(r_count))
        else $error("instruction retired while halted");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_valid |-> o_in_ready)
        else $error("input stalled with empty input stage");

endmodule

`default_nettype wire
